### rtl/core/ppme_pkg.sv
// ----------------------------------------------------------------------------
// ppme_pkg
// Shared types and constants for the pixel plotter with mono byte expansion.
// ----------------------------------------------------------------------------
package ppme_pkg;

	localparam int COORD_BITS = 14;
	localparam int ADDR_BITS  = 48;
	localparam int CLIP_BITS  = 15;
	localparam int PITCH_BITS = 17;
	localparam int BPP_BITS   = 6;
	localparam int POS_BITS   = 5;
	localparam int COLOR_BITS = 24;
	localparam int DATA_BITS  = 32;
	localparam int PROD_BITS  = COORD_BITS + PITCH_BITS;
	localparam int IDX_BITS   = 4;

	localparam logic [IDX_BITS-1:0] REG_BASE   = 4'd0;
	localparam logic [IDX_BITS-1:0] REG_WIDTH  = 4'd1;
	localparam logic [IDX_BITS-1:0] REG_HEIGHT = 4'd2;
	localparam logic [IDX_BITS-1:0] REG_PITCH  = 4'd3;
	localparam logic [IDX_BITS-1:0] REG_BPP    = 4'd4;
	localparam logic [IDX_BITS-1:0] REG_RED    = 4'd5;
	localparam logic [IDX_BITS-1:0] REG_GREEN  = 4'd6;
	localparam logic [IDX_BITS-1:0] REG_BLUE   = 4'd7;

	localparam logic             CMD_PIXEL = 1'b0;
	localparam logic             CMD_MONO  = 1'b1;
	localparam logic [BPP_BITS-1:0] BPP_24 = 6'd24;
	localparam logic [BPP_BITS-1:0] BPP_32 = 6'd32;
	localparam logic [2:0]       BYTES_24  = 3'd3;
	localparam logic [2:0]       BYTES_32  = 3'd4;

	typedef struct packed {
		logic                  cmd;
		logic [COORD_BITS-1:0] pos_x;
		logic [COORD_BITS-1:0] pos_y;
		logic [COLOR_BITS-1:0] color;
		logic [COLOR_BITS-1:0] back_color;
		logic [7:0]            mono_bits;
	} in_word_t;

	typedef struct packed {
		logic [ADDR_BITS-1:0] write_address;
		logic [DATA_BITS-1:0] write_data;
		logic [2:0]           write_bytes;
		logic                 last_write;
	} out_word_t;

	typedef struct packed {
		logic [ADDR_BITS-1:0]  base_address;
		logic [CLIP_BITS-1:0]  surface_width;
		logic [CLIP_BITS-1:0]  surface_height;
		logic [PITCH_BITS-1:0] row_pitch;
		logic [BPP_BITS-1:0]   bits_per_pixel;
		logic [POS_BITS-1:0]   red_position;
		logic [POS_BITS-1:0]   green_position;
		logic [POS_BITS-1:0]   blue_position;
	} cfg_t;

	typedef struct packed {
		logic [PROD_BITS-1:0]  row_offset;
		logic [COORD_BITS-1:0] pos_x;
		logic [COLOR_BITS-1:0] fg;
		logic [COLOR_BITS-1:0] bg;
		logic [7:0]            bits;
		logic [7:0]            mask;
	} job_t;

endpackage

### rtl/core/pixel_plotter_mono_expand_top.sv
// ----------------------------------------------------------------------------
// pixel_plotter_mono_expand_top
// Turns put-pixel and mono-byte drawing words into framebuffer write words.
// ----------------------------------------------------------------------------
// The input channel takes one drawing word per cycle while the job queue has
// room. A put-pixel word gives at most one write; a mono-byte word gives up to
// eight writes, one per pixel inside the surface, left to right, with
// last_write set on the final one. Words that hit nothing give no write.
// The output channel carries one write word per cycle from a register while
// the receiver is ready, so a pixel stream runs at one word per cycle. The
// first write of a word is registered in the queue when the word is accepted,
// then in the pixel walker and then in the output register. A mono byte holds
// the walker until all of its visible pixels have been issued.
// The configuration channel is always ready and writes one register per
// word; it is meant to be used only while no drawing work is pending.
// Reset empties the queue and the output register and loads the default
// configuration, with a zero base address, so nothing is written until the
// registers are set. When the receiver stalls, the output word holds, the
// walker waits, and the queue fills before the input channel stalls.
// ----------------------------------------------------------------------------
module pixel_plotter_mono_expand_top import ppme_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_word_t             in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_word_t            out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [IDX_BITS-1:0]  cfg_index,
	input  logic [ADDR_BITS-1:0] cfg_data
);

	cfg_t cfg_q;
	logic push;
	logic pop;
	logic full;
	logic empty;
	job_t job;
	job_t head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_address   <= '0;
			cfg_q.surface_width  <= '0;
			cfg_q.surface_height <= '0;
			cfg_q.row_pitch      <= '0;
			cfg_q.bits_per_pixel <= BPP_32;
			cfg_q.red_position   <= 5'd16;
			cfg_q.green_position <= 5'd8;
			cfg_q.blue_position  <= 5'd0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_BASE:   cfg_q.base_address   <= cfg_data;
				REG_WIDTH:  cfg_q.surface_width  <= cfg_data[CLIP_BITS-1:0];
				REG_HEIGHT: cfg_q.surface_height <= cfg_data[CLIP_BITS-1:0];
				REG_PITCH:  cfg_q.row_pitch      <= cfg_data[PITCH_BITS-1:0];
				REG_BPP:    cfg_q.bits_per_pixel <= cfg_data[BPP_BITS-1:0];
				REG_RED:    cfg_q.red_position   <= cfg_data[POS_BITS-1:0];
				REG_GREEN:  cfg_q.green_position <= cfg_data[POS_BITS-1:0];
				REG_BLUE:   cfg_q.blue_position  <= cfg_data[POS_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	ppme_front u_front (
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.queue_full (full),
		.push       (push),
		.job        (job)
	);

	ppme_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (job),
		.pop    (pop),
		.rdata  (head),
		.full   (full),
		.empty  (empty)
	);

	ppme_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.head        (head),
		.queue_empty (empty),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data)
	);

endmodule

### rtl/core/ppme_front.sv
// ----------------------------------------------------------------------------
// ppme_front
// Accepts drawing words, clips them and forms the pixel mask and row offset.
// ----------------------------------------------------------------------------
module ppme_front import ppme_pkg::*; (
	input  cfg_t     cfg,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_word_t in_data,
	input  logic     queue_full,
	output logic     push,
	output job_t     job
);

	logic       enable;
	logic [7:0] mask;

	always_comb begin
		logic [CLIP_BITS-1:0] px;
		enable = (cfg.base_address != '0)
			&& (cfg.bits_per_pixel inside {BPP_24, BPP_32})
			&& (CLIP_BITS'(in_data.pos_y) < cfg.surface_height);
		mask = '0;
		for (int k = 0; k < 8; k++) begin
			px = CLIP_BITS'(in_data.pos_x) + CLIP_BITS'(k);
			mask[k] = px < cfg.surface_width;
		end
		if (in_data.cmd == CMD_PIXEL) begin
			mask = {7'b0, mask[0]};
		end
		if (!enable) begin
			mask = '0;
		end
	end

	assign in_ready = !queue_full;
	assign push     = in_valid && !queue_full && (mask != '0);

	assign job.row_offset = PROD_BITS'(in_data.pos_y) * PROD_BITS'(cfg.row_pitch);
	assign job.pos_x      = in_data.pos_x;
	assign job.fg         = in_data.color;
	assign job.bg         = in_data.back_color;
	assign job.bits       = (in_data.cmd == CMD_MONO) ? in_data.mono_bits : 8'h80;
	assign job.mask       = mask;

endmodule

### rtl/core/ppme_queue.sv
// ----------------------------------------------------------------------------
// ppme_queue
// Small register FIFO of classified jobs between the front and back parts.
// ----------------------------------------------------------------------------
module ppme_queue import ppme_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t wdata,
	input  logic pop,
	output job_t rdata,
	output logic full,
	output logic empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = count_q == CNT_W'(DEPTH);
	assign empty = count_q == '0;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

`ifndef SYNTHESIS
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("Job pushed into a full queue.");
	a_pop_data: assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("Job popped from an empty queue.");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("Queue fill count lost a push.");
`endif

endmodule

### rtl/core/ppme_back.sv
// ----------------------------------------------------------------------------
// ppme_back
// Walks the pixel mask of one job and issues one packed write per pixel.
// ----------------------------------------------------------------------------
module ppme_back import ppme_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  job_t      head,
	input  logic      queue_empty,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_data
);

	job_t       work_q;
	logic [7:0] work_mask_q;
	logic       work_valid_q;
	out_word_t  out_q;
	logic       out_valid_q;

	logic                  emit;
	logic                  load;
	logic [2:0]            sel;
	logic [7:0]            next_mask;
	logic [COLOR_BITS-1:0] rgb;
	logic [ADDR_BITS-1:0]  offset;
	out_word_t             word;

	always_comb begin
		logic [CLIP_BITS-1:0] px;
		logic                 is24;
		sel = '0;
		for (int k = 7; k >= 0; k--) begin
			if (work_mask_q[k]) begin
				sel = 3'(k);
			end
		end
		next_mask = work_mask_q & ~(8'b1 << sel);
		rgb = work_q.bits[3'd7 - sel] ? work_q.fg : work_q.bg;
		px = CLIP_BITS'(work_q.pos_x) + CLIP_BITS'(sel);
		is24 = cfg.bits_per_pixel == BPP_24;
		offset = is24 ? ((ADDR_BITS'(px) << 1) + ADDR_BITS'(px)) : (ADDR_BITS'(px) << 2);
		word.write_address = cfg.base_address + ADDR_BITS'(work_q.row_offset) + offset;
		word.write_data = (DATA_BITS'(rgb[23:16]) << cfg.red_position)
			| (DATA_BITS'(rgb[15:8]) << cfg.green_position)
			| (DATA_BITS'(rgb[7:0]) << cfg.blue_position);
		word.write_bytes = is24 ? BYTES_24 : BYTES_32;
		word.last_write = next_mask == '0;
	end

	assign emit = work_valid_q && (!out_valid_q || out_ready);
	assign load = !work_valid_q || (emit && word.last_write);
	assign pop  = load && !queue_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (load) begin
				work_valid_q <= !queue_empty;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			work_q      <= head;
			work_mask_q <= head.mask;
		end else if (emit) begin
			work_mask_q <= next_mask;
		end
		if (emit) begin
			out_q <= word;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
